>>> hw/rtl/positional_list_engine_top_assert.svh
// assertion macros for the positional list engine
// used by positional_list_engine_top.sv, no other dependencies
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PLE_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("positional list engine: assertion failed");

// antecedent implies consequent in the next cycle
`define PLE_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("positional list engine: assertion failed");

`endif

>>> hw/rtl/ple_pkg.sv
// shared types, codes and elaboration helpers for the positional list engine
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ple_pkg;

    // default sizes and fixed field widths
    localparam int DEPTH_DEF      = 64;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int OP_W           = 3;
    localparam int POS_W          = 7;
    localparam int VAL_W          = 32;
    localparam int STATUS_W       = 2;
    localparam int LEN_W          = 7;
    localparam int FAN_IN         = 8;
    localparam int FAN_SH         = 3;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD_FRONT    = 3'd0,
        OP_ADD_REAR     = 3'd1,
        OP_REMOVE_FRONT = 3'd2,
        OP_REMOVE_REAR  = 3'd3,
        OP_INSERT_AT    = 3'd4,
        OP_REMOVE_AT    = 3'd5
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // shift command broadcast to the cell row
    typedef struct packed {
        logic go;
        logic ins;
        logic rem;
    } shift_ctl_t;

    // node count of a given level of the select tree (level 0 = cells)
    function automatic int tree_nodes(input int n, input int k);
        int m;
        int i;
        m = n;
        for (i = 0; i < k; i++)
        begin
            m = (m + FAN_IN - 1) >> FAN_SH;
        end
        return m;
    endfunction

    // number of registered levels down to a single node
    function automatic int tree_levels(input int n);
        int m;
        int l;
        m = n;
        l = 0;
        while (m > 1)
        begin
            m = (m + FAN_IN - 1) >> FAN_SH;
            l = l + 1;
        end
        return l;
    endfunction

    // first node of a level in the flat tree bus
    function automatic int tree_offset(input int n, input int k);
        int s;
        int i;
        s = 0;
        for (i = 0; i < k; i++)
        begin
            s = s + tree_nodes(n, i);
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/ple_cell.sv
// one element cell of the shifting list row
// depends on ple_pkg for the shift command type
`timescale 1ns / 1ps

module ple_cell #(
    parameter int ELEM_W = ple_pkg::ELEM_WIDTH_DEF,
    parameter int IDX_W  = 6,
    parameter int IDX    = 0
) (
    input  logic                   clk,
    input  ple_pkg::shift_ctl_t    ctl,
    input  logic [IDX_W-1:0]       idx,
    input  logic [ELEM_W-1:0]      din,
    input  logic [ELEM_W-1:0]      left_data,
    input  logic [ELEM_W-1:0]      right_data,
    output logic [ELEM_W-1:0]      data,
    output logic [ELEM_W-1:0]      sel_data
);

    logic [ELEM_W-1:0] data_reg;
    logic [ELEM_W-1:0] data_next;
    logic              hit;
    logic              behind;

    // position of this cell relative to the target index
    assign hit    = (idx == IDX_W'(IDX));
    assign behind = (idx < IDX_W'(IDX));

    // insert pulls from the front neighbor, remove pulls from the rear one
    always_comb
    begin
        data_next = data_reg;
        if (ctl.go)
        begin
            if (ctl.ins)
            begin
                if (hit)
                    data_next = din;
                else if (behind)
                    data_next = left_data;
            end
            else if (ctl.rem)
            begin
                if (hit || behind)
                    data_next = right_data;
            end
        end
    end

    // element storage
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // contents offered to the select tree when this cell is removed
    assign data     = data_reg;
    assign sel_data = data_reg & {ELEM_W{ctl.go & ctl.rem & hit}};

endmodule

>>> hw/rtl/ple_or_level.sv
// one registered level of the removed-value select tree
// eight inputs per node are or-ed; depends on ple_pkg for the fan-in
`timescale 1ns / 1ps

module ple_or_level #(
    parameter int N_IN   = 8,
    parameter int ELEM_W = ple_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                              clk,
    input  logic                                              en,
    input  logic [N_IN*ELEM_W-1:0]                            din,
    output logic [((N_IN+ple_pkg::FAN_IN-1)/ple_pkg::FAN_IN)*ELEM_W-1:0] dout
);

    localparam int N_OUT = (N_IN + ple_pkg::FAN_IN - 1) / ple_pkg::FAN_IN;

    logic [ELEM_W-1:0] kid   [N_OUT][ple_pkg::FAN_IN];
    logic [ELEM_W-1:0] or_n  [N_OUT];
    logic [ELEM_W-1:0] node_reg [N_OUT];

    // children of each node, padding past the last input
    for (genvar o = 0; o < N_OUT; o++)
    begin : g_node
        for (genvar c = 0; c < ple_pkg::FAN_IN; c++)
        begin : g_kid
            if (o * ple_pkg::FAN_IN + c < N_IN)
            begin : g_real
                assign kid[o][c] = din[(o*ple_pkg::FAN_IN+c)*ELEM_W +: ELEM_W];
            end
            else
            begin : g_pad
                assign kid[o][c] = '0;
            end
        end
        assign dout[o*ELEM_W +: ELEM_W] = node_reg[o];
    end

    // at most one leaf is selected, so or-ing picks it out
    always_comb
    begin
        for (int o = 0; o < N_OUT; o++)
        begin
            or_n[o] = '0;
            for (int c = 0; c < ple_pkg::FAN_IN; c++)
            begin
                or_n[o] = or_n[o] | kid[o][c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int o = 0; o < N_OUT; o++)
            begin
                node_reg[o] <= or_n[o];
            end
        end
    end

endmodule

>>> hw/rtl/positional_list_engine_top.sv
// Positional list engine: a bounded ordered list of up to DEPTH elements held in a row of
// shifting cells, front at cell 0. Each transfer on the input channel names one operation
// (add front/rear, remove front/rear, insert before or remove a 1-based position) and gives
// exactly one result transfer with status, removed value and new length. An item is decoded
// against the element count in its accept cycle, the cell row shifts in the next cycle, and
// the removed element is picked out by a registered eight-way or-tree over the cells of
// LEVELS = ceil(log8(DEPTH)) levels. The next item is taken only after the result has moved
// into the output register, so a stalled output keeps the engine busy. A finished result
// waits in the output register while the next item is taken.
// depends on ple_pkg, ple_cell, ple_or_level and positional_list_engine_top_assert.svh
`timescale 1ns / 1ps

module positional_list_engine_top #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = ple_pkg::ELEM_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ple_pkg::OP_W-1:0]          op,
    input  logic [ple_pkg::POS_W-1:0]         position,
    input  logic signed [ple_pkg::VAL_W-1:0]  value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ple_pkg::STATUS_W-1:0]      status,
    output logic signed [ple_pkg::VAL_W-1:0]  removed_value,
    output logic [ple_pkg::LEN_W-1:0]         length
);

    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int PW          = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;
    localparam int TREE_LEVELS = ple_pkg::tree_levels(DEPTH);
    localparam int TREE_TOTAL  = ple_pkg::tree_offset(DEPTH, TREE_LEVELS + 1);
    localparam int STG_W       = $clog2(TREE_LEVELS + 1);

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } state_t;

    state_t                       state_reg;
    logic [STG_W-1:0]             stage_reg;
    logic [CNT_W-1:0]             count_reg;
    ple_pkg::shift_ctl_t          ctl_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [ELEM_WIDTH-1:0]        din_reg;
    ple_pkg::status_t             res_status_reg;
    logic [ple_pkg::LEN_W-1:0]    res_length_reg;
    logic                         out_valid_reg;
    ple_pkg::status_t             status_reg;
    logic signed [ple_pkg::VAL_W-1:0] removed_reg;
    logic [ple_pkg::LEN_W-1:0]    length_reg;

    logic                         accept;
    logic                         res_load;
    logic                         tree_en;
    logic                         full;
    logic                         empty;
    logic [PW-1:0]                pos_w;
    logic [PW-1:0]                cnt_w;
    logic [PW-1:0]                pos_m1;
    logic [CNT_W-1:0]             rear_idx;
    ple_pkg::status_t             st_next;
    logic                         ins_next;
    logic                         rem_next;
    logic [IDX_W-1:0]             idx_next;
    logic [CNT_W-1:0]             cnt_next;
    ple_pkg::shift_ctl_t          ctl_next;

    logic [ELEM_WIDTH-1:0]        cell_data [DEPTH];
    logic [TREE_TOTAL*ELEM_WIDTH-1:0] tree_bus;
    logic [ELEM_WIDTH-1:0]        tree_top;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;

    // finished result moves into the output register when it is free
    assign res_load = (state_reg == S_BUSY) && (stage_reg == STG_W'(TREE_LEVELS))
                      && (!out_valid_reg || out_ready);

    // operation decode against the current count
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pos_w    = PW'(position);
    assign cnt_w    = PW'(count_reg);
    assign pos_m1   = pos_w - PW'(1);
    assign rear_idx = count_reg - CNT_W'(1);

    always_comb
    begin
        st_next  = ple_pkg::ST_OK;
        ins_next = 1'b0;
        rem_next = 1'b0;
        idx_next = '0;
        unique case (op)
            ple_pkg::OP_ADD_FRONT:
            begin
                if (full)
                    st_next = ple_pkg::ST_FULL;
                else
                    ins_next = 1'b1;
            end
            ple_pkg::OP_ADD_REAR:
            begin
                if (full)
                    st_next = ple_pkg::ST_FULL;
                else
                begin
                    ins_next = 1'b1;
                    idx_next = count_reg[IDX_W-1:0];
                end
            end
            ple_pkg::OP_REMOVE_FRONT:
            begin
                if (empty)
                    st_next = ple_pkg::ST_UNDERFLOW;
                else
                    rem_next = 1'b1;
            end
            ple_pkg::OP_REMOVE_REAR:
            begin
                if (empty)
                    st_next = ple_pkg::ST_UNDERFLOW;
                else
                begin
                    rem_next = 1'b1;
                    idx_next = rear_idx[IDX_W-1:0];
                end
            end
            ple_pkg::OP_INSERT_AT:
            begin
                if (pos_w == '0 || pos_w > cnt_w + PW'(1))
                    st_next = ple_pkg::ST_RANGE;
                else if (full)
                    st_next = ple_pkg::ST_FULL;
                else
                begin
                    ins_next = 1'b1;
                    idx_next = pos_m1[IDX_W-1:0];
                end
            end
            ple_pkg::OP_REMOVE_AT:
            begin
                if (pos_w == '0 || pos_w > cnt_w)
                    st_next = ple_pkg::ST_RANGE;
                else
                begin
                    rem_next = 1'b1;
                    idx_next = pos_m1[IDX_W-1:0];
                end
            end
            default:
            begin
                st_next = ple_pkg::ST_RANGE;
            end
        endcase
    end

    // new element count
    always_comb
    begin
        priority if (ins_next)
            cnt_next = count_reg + CNT_W'(1);
        else if (rem_next)
            cnt_next = count_reg - CNT_W'(1);
        else
            cnt_next = count_reg;
    end

    // shift command, pulsed in the cycle after accept
    always_comb
    begin
        ctl_next.go  = accept;
        ctl_next.ins = ins_next;
        ctl_next.rem = rem_next;
    end

    // sequencer, count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            stage_reg      <= '0;
            count_reg      <= '0;
            ctl_reg        <= '0;
            res_status_reg <= ple_pkg::ST_OK;
            res_length_reg <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ple_pkg::ST_OK;
            removed_reg    <= '0;
            length_reg     <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg      <= S_BUSY;
                        stage_reg      <= '0;
                        count_reg      <= cnt_next;
                        res_status_reg <= st_next;
                        res_length_reg <= ple_pkg::LEN_W'(cnt_next);
                    end
                end
                S_BUSY:
                begin
                    if (stage_reg != STG_W'(TREE_LEVELS))
                        stage_reg <= stage_reg + STG_W'(1);
                    else if (res_load)
                    begin
                        status_reg    <= res_status_reg;
                        removed_reg   <= ple_pkg::VAL_W'($signed(tree_top));
                        length_reg    <= res_length_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // command payload for the cell row
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= idx_next;
            din_reg <= ELEM_WIDTH'(value);
        end
    end

    // row of shifting cells, front at index 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ELEM_WIDTH-1:0] left_d;
        logic [ELEM_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = cell_data[i];
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        ple_cell #(
            .ELEM_W (ELEM_WIDTH),
            .IDX_W  (IDX_W),
            .IDX    (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl_reg),
            .idx        (idx_reg),
            .din        (din_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .sel_data   (tree_bus[i*ELEM_WIDTH +: ELEM_WIDTH])
        );
    end

    // registered select tree for the removed element
    assign tree_en = (state_reg == S_BUSY) && (stage_reg != STG_W'(TREE_LEVELS));

    for (genvar k = 1; k <= TREE_LEVELS; k++)
    begin : g_lvl
        localparam int N_IN  = ple_pkg::tree_nodes(DEPTH, k - 1);
        localparam int N_OUT = ple_pkg::tree_nodes(DEPTH, k);
        localparam int OFF_I = ple_pkg::tree_offset(DEPTH, k - 1);
        localparam int OFF_O = ple_pkg::tree_offset(DEPTH, k);

        ple_or_level #(
            .N_IN   (N_IN),
            .ELEM_W (ELEM_WIDTH)
        ) u_lvl (
            .clk  (clk),
            .en   (tree_en),
            .din  (tree_bus[OFF_I*ELEM_WIDTH +: N_IN*ELEM_WIDTH]),
            .dout (tree_bus[OFF_O*ELEM_WIDTH +: N_OUT*ELEM_WIDTH])
        );
    end

    assign tree_top = tree_bus[(TREE_TOTAL-1)*ELEM_WIDTH +: ELEM_WIDTH];

    // result ports
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign length        = length_reg;

    // checks
`include "positional_list_engine_top_assert.svh"

    `PLE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `PLE_ASSERT_NEXT(a_insert_grows, clk, rst_n, accept && ins_next,
        count_reg == $past(count_reg) + CNT_W'(1))
    `PLE_ASSERT_NOW(a_shift_once, clk, rst_n, ctl_reg.go,
        state_reg == S_BUSY && stage_reg == '0)
    `PLE_ASSERT_NOW(a_removed_zero, clk, rst_n,
        out_valid_reg && status_reg != ple_pkg::ST_OK, removed_reg == '0)

endmodule
